>>> src/wtkm_pkg.sv
// shared types and constants for the winner-tree k-way merge
package wtkm_pkg;

  // fixed field widths of the command and result ports
  localparam int unsigned RUN_SEL_W = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned VAL_W     = 16;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // write one run slot
    logic resolve;  // emit the tree winner and advance its run
    logic fill;     // write the fetched slot into the run head
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic root_vld;  // some run still holds a value
    logic refill;    // winner run has a next slot to fetch
  } dp_sts_t;

endpackage

>>> src/wtkm_ctrl.sv
// control state machine for the winner-tree k-way merge
module wtkm_ctrl #(
  parameter int unsigned LEVELS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              action_i,
  input  wtkm_pkg::dp_sts_t sts_i,
  output logic              busy_o,
  output wtkm_pkg::dp_cmd_t cmd_o
);
  import wtkm_pkg::*;

  localparam int unsigned CNT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_FETCH  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_POP) begin
            state_d = ST_SETTLE;
            cnt_d   = CNT_W'(LEVELS - 1);
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SETTLE: begin
        // wait until the registered tree has seen the current heads
        if (cnt_q == '0) begin
          cmd_o.resolve = 1'b1;
          state_d = (sts_i.root_vld && sts_i.refill) ? ST_FETCH : ST_IDLE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_FETCH: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/wtkm_dp.sv
// run store, run heads, read pointers and registered winner tree
module wtkm_dp #(
  parameter int unsigned RUNS       = 8,
  parameter int unsigned RUN_LEN    = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wtkm_pkg::dp_cmd_t                     cmd_i,
  output wtkm_pkg::dp_sts_t                     sts_o,
  input  logic [wtkm_pkg::RUN_SEL_W-1:0]        run_sel_i,
  input  logic [wtkm_pkg::POS_W-1:0]            position_i,
  input  logic signed [wtkm_pkg::VAL_W-1:0]     value_i,
  output logic                                  out_valid_o,
  output logic signed [wtkm_pkg::VAL_W-1:0]     out_value_o,
  output logic [wtkm_pkg::RUN_SEL_W-1:0]        out_run_o,
  output logic                                  empty_res_o
);
  import wtkm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(RUNS);
  localparam int unsigned P      = 1 << IDX_W;
  localparam int unsigned PTR_W  = $clog2(RUN_LEN + 1);
  localparam int unsigned DEPTH  = RUNS * RUN_LEN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef struct packed {
    logic                         vld;
    logic [IDX_W-1:0]             idx;
    logic signed [VALUE_BITS-1:0] val;
  } node_t;

  function automatic node_t pick(node_t l, node_t r);
    node_t w;
    // left subtree holds the lower run numbers, so ties go left
    if (!l.vld) w = r;
    else if (!r.vld) w = l;
    else if ($signed(l.val) <= $signed(r.val)) w = l;
    else w = r;
    return w;
  endfunction

  logic signed [VALUE_BITS-1:0] mem_q [DEPTH];
  logic signed [VALUE_BITS-1:0] rdata_q;
  logic signed [VALUE_BITS-1:0] head_q [RUNS];
  logic [PTR_W-1:0]             ptr_q [RUNS];
  logic [IDX_W-1:0]             win_q;
  node_t                        node_q [1:P-1];
  node_t                        all_n [2*P];
  node_t                        root;

  logic                         out_vld_q;
  logic signed [VAL_W-1:0]      out_value_q;
  logic [RUN_SEL_W-1:0]         out_run_q;
  logic                         empty_q;

  logic                         ld_ok;
  logic [IDX_W-1:0]             ld_run;
  logic [PTR_W-1:0]             ld_pos;
  logic [ADDR_W-1:0]            ld_addr;
  logic signed [VALUE_BITS-1:0] ld_val;
  logic [PTR_W-1:0]             ptr_nx;
  logic [ADDR_W-1:0]            rd_addr;

  // load decode, out-of-range slots are dropped
  assign ld_ok   = cmd_i.load && (32'(run_sel_i) < RUNS) && (32'(position_i) < RUN_LEN);
  assign ld_run  = IDX_W'(run_sel_i);
  assign ld_pos  = PTR_W'(position_i);
  assign ld_addr = ADDR_W'(ld_run) * ADDR_W'(RUN_LEN) + ADDR_W'(ld_pos);
  assign ld_val  = VALUE_BITS'(value_i);

  // tree: internal nodes from registers, leaves from the run heads
  always_comb begin
    all_n[0] = '0;
    for (int i = 1; i < P; i++) begin
      all_n[i] = node_q[i];
    end
    for (int j = 0; j < P; j++) begin
      if (j < RUNS) begin
        all_n[P+j].vld = (32'(ptr_q[j]) < RUN_LEN);
        all_n[P+j].idx = IDX_W'(j);
        all_n[P+j].val = head_q[j];
      end else begin
        all_n[P+j] = '0;
      end
    end
  end

  for (genvar i = 1; i < P; i++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[i] <= pick(all_n[2*i], all_n[2*i+1]);
    end
  end

  assign root    = node_q[1];
  assign ptr_nx  = ptr_q[root.idx] + PTR_W'(1);
  assign rd_addr = ADDR_W'(root.idx) * ADDR_W'(RUN_LEN) + ADDR_W'(ptr_nx);

  assign sts_o.root_vld = root.vld;
  assign sts_o.refill   = (32'(ptr_nx) < RUN_LEN);

  // run store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ld_ok) begin
      mem_q[ld_addr] <= ld_val;
    end
    if (cmd_i.resolve && root.vld && sts_o.refill) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      win_q <= root.idx;
    end
  end

  // run heads follow the slot under each read pointer
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < RUNS; r++) begin
      if (cmd_i.fill && (32'(win_q) == r)) begin
        head_q[r] <= rdata_q;
      end else if (ld_ok && (32'(ld_run) == r) && (ptr_q[r] == ld_pos)) begin
        head_q[r] <= ld_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RUNS; r++) begin
        ptr_q[r] <= '0;
      end
    end else if (cmd_i.resolve && root.vld) begin
      ptr_q[root.idx] <= ptr_nx;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cmd_i.resolve;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      out_value_q <= root.vld ? VAL_W'(root.val) : '0;
      out_run_q   <= root.vld ? RUN_SEL_W'(root.idx) : '0;
      empty_q     <= !root.vld;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_value_q;
  assign out_run_o   = out_run_q;
  assign empty_res_o = empty_q;

endmodule

>>> src/winner_tree_kway_merge.sv
// top level of the winner-tree k-way merge
//
// Holds RUNS sorted runs of RUN_LEN values. A command is taken at a clock
// edge with start high and busy low. action_i = load writes value_i into
// slot position_i of run run_sel_i and gives no result; slots outside
// the configured runs are ignored.
// action_i = pop returns the smallest run head and its run number (ties to
// the lower run) and advances that run. With every run used up, a pop
// returns empty_res_o = 1 with value and run zero.
// A pop result shows on out_value_o, out_run_o and empty_res_o for one
// cycle with out_valid_o high, once the registered winner tree has settled.
// busy stays high while the registered winner tree settles and, when
// the winning run has a next slot, while that slot is read from the run
// store into the run head.
// Results cannot be held off; a new command may be taken while the
// previous result is on the ports.
// Reset clears all read pointers and the control state; run slots hold
// whatever was last written.
module winner_tree_kway_merge #(
  parameter int unsigned RUNS       = 8,
  parameter int unsigned RUN_LEN    = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action_i,
  input  logic [wtkm_pkg::RUN_SEL_W-1:0]    run_sel_i,
  input  logic [wtkm_pkg::POS_W-1:0]        position_i,
  input  logic signed [wtkm_pkg::VAL_W-1:0] value_i,
  output logic                              out_valid_o,
  output logic signed [wtkm_pkg::VAL_W-1:0] out_value_o,
  output logic [wtkm_pkg::RUN_SEL_W-1:0]    out_run_o,
  output logic                              empty_res_o
);
  import wtkm_pkg::*;

  localparam int unsigned LEVELS = $clog2(RUNS);

  dp_cmd_t cmd;
  dp_sts_t sts;

  wtkm_ctrl #(
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .sts_i    (sts),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  wtkm_dp #(
    .RUNS       (RUNS),
    .RUN_LEN    (RUN_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .run_sel_i   (run_sel_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_value_o (out_value_o),
    .out_run_o   (out_run_o),
    .empty_res_o (empty_res_o)
  );

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the winner-tree k-way merge
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wtkm_pkg::*;

  localparam int unsigned RUNS         = 8;
  localparam int unsigned RUN_LEN      = 16;
  localparam int unsigned RAND_CMDS    = 1600;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_CYCLES   = 200000;
  localparam int unsigned N_DIR        = 23;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [RUN_SEL_W-1:0]    run;
    logic                    empty;
  } pop_res_t;

  typedef struct packed {
    logic                    action;
    logic [RUN_SEL_W-1:0]    run_sel;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } merge_cmd_t;

  typedef struct packed {
    merge_cmd_t cmd;
    logic       fixed_exp;
    pop_res_t   res;
  } dir_row_t;

  // runs start from the preload; heads rewritten here to force extremes and ties
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{ACT_LOAD, 3'd0, 4'd0,  16'sh8000}, 1'b0, '0},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b1, '{16'sh8000, 3'd0, 1'b0}},
    '{'{ACT_LOAD, 3'd0, 4'd1,  16'sh8000}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd4, 4'd0,  16'sh8000}, 1'b0, '0},
    // equal heads: lower run goes first
    '{'{ACT_POP,  3'd7, 4'd15, 16'shffff}, 1'b1, '{16'sh8000, 3'd0, 1'b0}},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b1, '{16'sh8000, 3'd4, 1'b0}},
    '{'{ACT_LOAD, 3'd7, 4'd0,  16'sh7fff}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd3, 4'd0,  16'sh7fff}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd1, 4'd0,  16'sh5555}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd1, 4'd0,  16'shaaaa}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd2, 4'd0,  16'sh8000}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd2, 4'd0,  16'sh0064}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd5, 4'd0,  16'sh8000}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd6, 4'd0,  16'sh8000}, 1'b0, '0},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b1, '{16'sh8000, 3'd5, 1'b0}},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b1, '{16'sh8000, 3'd6, 1'b0}},
    '{'{ACT_LOAD, 3'd5, 4'd15, 16'sh7fff}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd7, 4'd15, 16'shffff}, 1'b0, '0},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b0, '0},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b0, '0},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b0, '0},
    '{'{ACT_LOAD, 3'd0, 4'd2,  16'sh0000}, 1'b0, '0},
    '{'{ACT_POP,  3'd0, 4'd0,  16'sh0000}, 1'b0, '0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    action_i;
  logic [RUN_SEL_W-1:0]    run_sel_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic [RUN_SEL_W-1:0]    out_run_o;
  logic                    empty_res_o;

  // shadow of the run store and the read pointers
  logic signed [VAL_W-1:0] slot_val [RUNS][RUN_LEN];
  int unsigned             head_ptr [RUNS];

  pop_res_t    expected_pops [$];
  int unsigned errors    = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct  = 36;

  winner_tree_kway_merge #(
    .RUNS       (RUNS),
    .RUN_LEN    (RUN_LEN),
    .VALUE_BITS (16)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .run_sel_i   (run_sel_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_value_o (out_value_o),
    .out_run_o   (out_run_o),
    .empty_res_o (empty_res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // smallest live head, lowest run on ties; advances the winning run
  function automatic pop_res_t take_min_head();
    pop_res_t                r;
    logic signed [VAL_W-1:0] best;
    int                      win;
    r    = '0;
    best = '0;
    win  = -1;
    for (int k = 0; k < RUNS; k++) begin
      if (head_ptr[k] < RUN_LEN) begin
        if (win < 0 || slot_val[k][head_ptr[k]] < best) begin
          best = slot_val[k][head_ptr[k]];
          win  = k;
        end
      end
    end
    if (win < 0) begin
      r.empty = 1'b1;
    end else begin
      r.value = best;
      r.run   = RUN_SEL_W'(win);
      head_ptr[win]++;
    end
    return r;
  endfunction

  task automatic issue(input merge_cmd_t c, input logic fixed_exp, input pop_res_t fixed_res);
    pop_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= c.action;
    run_sel_i  <= c.run_sel;
    position_i <= c.position;
    value_i    <= c.value;
    do @(posedge clk_i); while (busy);
    if (c.action == ACT_POP) begin
      res = take_min_head();
      expected_pops.push_back(fixed_exp ? fixed_res : res);
    end else begin
      slot_val[c.run_sel][c.position] = c.value;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    pop_res_t exp_r;
    if (rst_ni && out_valid_o) begin
      if (expected_pops.size() == 0) begin
        $display("%0t: unexpected result: value %0d run %0d empty %0b", $time,
                 out_value_o, out_run_o, empty_res_o);
        errors++;
      end else begin
        exp_r = expected_pops.pop_front();
        if (out_value_o !== exp_r.value) begin
          $display("%0t: out_value expected %0d got %0d", $time,
                   $signed(exp_r.value), out_value_o);
          errors++;
        end
        if (out_run_o !== exp_r.run) begin
          $display("%0t: out_run expected %0d got %0d", $time, exp_r.run, out_run_o);
          errors++;
        end
        if (empty_res_o !== exp_r.empty) begin
          $display("%0t: empty_res expected %0b got %0b", $time, exp_r.empty, empty_res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("** winner_tree_kway_merge: FAILED **");
      $finish;
    end
  end

  initial begin
    merge_cmd_t c;
    int         v;
    int         other;
    logic       live;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    action_i   <= ACT_LOAD;
    run_sel_i  <= '0;
    position_i <= '0;
    value_i    <= '0;
    for (int r = 0; r < RUNS; r++) head_ptr[r] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // preload every slot with sorted runs, so no pop ever sees an unwritten slot
    for (int r = 0; r < RUNS; r++) begin
      v = int'($urandom_range(4000)) - 32767;
      for (int p = 0; p < RUN_LEN; p++) begin
        if (p != 0) v += 16 * int'($urandom_range(250));
        c.action   = ACT_LOAD;
        c.run_sel  = RUN_SEL_W'(r);
        c.position = POS_W'(p);
        c.value    = VAL_W'(v);
        issue(c, 1'b0, '0);
      end
    end

    for (int i = 0; i < N_DIR; i++) issue(DIR_TAB[i].cmd, DIR_TAB[i].fixed_exp, DIR_TAB[i].res);

    for (int i = 0; i < RAND_CMDS; i++) begin
      idle_pct = (i < RAND_CMDS / 3) ? 36 : (i < 2 * RAND_CMDS / 3) ? 60 : 0;
      live = 1'b0;
      for (int r = 0; r < RUNS; r++) if (head_ptr[r] < RUN_LEN) live = 1'b1;
      c.run_sel  = RUN_SEL_W'($urandom_range(RUNS - 1));
      c.position = POS_W'($urandom_range(RUN_LEN - 1));
      c.value    = VAL_W'($urandom);
      // pops are sparse while the merge runs so that head rewrites land in between
      if (live ? ($urandom_range(99) < 20) : ($urandom_range(1) == 1)) begin
        c.action = ACT_POP;
      end else begin
        c.action = ACT_LOAD;
        if (head_ptr[c.run_sel] < RUN_LEN && $urandom_range(3) != 0)
          c.position = POS_W'($urandom_range(RUN_LEN - 1, head_ptr[c.run_sel]));
        other = $urandom_range(RUNS - 1);
        if ($urandom_range(3) == 0 && head_ptr[other] < RUN_LEN)
          c.value = slot_val[other][head_ptr[other]];
      end
      issue(c, 1'b0, '0);
    end
    start <= 1'b0;

    while (expected_pops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("** winner_tree_kway_merge: PASSED **");
    end else begin
      $display("** winner_tree_kway_merge: FAILED **");
    end
    $finish;
  end

endmodule
